[hw/rtl/rlp_pkg.sv]
// Package for the radix literal parser: character codes, parse phases and
// the token that the front hands to the back through the queue.
// No dependencies.
`timescale 1ns / 1ps

package rlp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [5:0] RADIX_BIN   = 6'd2;
	localparam logic [5:0] RADIX_DEC   = 6'd10;
	localparam logic [5:0] RADIX_HEX   = 6'd16;

	localparam logic [7:0] CHAR_QUOTE  = 8'd39;
	localparam logic [7:0] CHAR_PCT    = 8'h25;
	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UA     = 8'h41;
	localparam logic [7:0] CHAR_UZ     = 8'h5A;
	localparam logic [7:0] CHAR_LA     = 8'h61;
	localparam logic [7:0] CHAR_LZ     = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [7:0] LETTER_BASE = 8'd10;

	typedef enum logic [2:0] {
		PH_START,
		PH_BIN,
		PH_DEC,
		PH_HEX,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       word_end;
		logic [1:0] pos;
		logic       is_quote;
		logic       is_pct;
		logic       is_hash;
		logic       is_dollar;
		logic       is_minus;
		logic       dig_ok;
		logic [5:0] dig_val;
	} token_t;

endpackage

[hw/rtl/rlp_front.sv]
// Front of the radix literal parser: accepts characters, tracks the position
// within the word and classifies each character into a token.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      char_code,
	input  logic            word_end,
	output logic            push_valid,
	input  logic            push_full,
	output rlp_pkg::token_t push_data
);

	logic [1:0] pos_q;
	logic [7:0] lower;
	logic       accept;

	assign in_stall   = push_full;
	assign accept     = in_valid && !push_full;
	assign push_valid = in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (accept) begin
			if (word_end) begin
				pos_q <= 2'd0;
			end else if (pos_q != 2'd3) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_comb begin
		lower = char_code;
		if (char_code inside {[rlp_pkg::CHAR_UA:rlp_pkg::CHAR_UZ]}) begin
			lower = char_code + rlp_pkg::CASE_OFFSET;
		end
		push_data           = '0;
		push_data.char_code = char_code;
		push_data.word_end  = word_end;
		push_data.pos       = pos_q;
		push_data.is_quote  = char_code == rlp_pkg::CHAR_QUOTE;
		push_data.is_pct    = char_code == rlp_pkg::CHAR_PCT;
		push_data.is_hash   = char_code == rlp_pkg::CHAR_HASH;
		push_data.is_dollar = char_code == rlp_pkg::CHAR_DOLLAR;
		push_data.is_minus  = char_code == rlp_pkg::CHAR_MINUS;
		if (lower inside {[rlp_pkg::CHAR_ZERO:rlp_pkg::CHAR_NINE]}) begin
			push_data.dig_ok  = 1'b1;
			push_data.dig_val = 6'(lower - rlp_pkg::CHAR_ZERO);
		end else if (lower inside {[rlp_pkg::CHAR_LA:rlp_pkg::CHAR_LZ]}) begin
			push_data.dig_ok  = 1'b1;
			push_data.dig_val = 6'(lower - rlp_pkg::CHAR_LA + rlp_pkg::LETTER_BASE);
		end
	end

endmodule

[hw/rtl/rlp_queue.sv]
// Token queue between front and back of the radix literal parser.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_queue #(
	parameter int unsigned Depth = rlp_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_full,
	input  rlp_pkg::token_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rlp_pkg::token_t pop_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	rlp_pkg::token_t mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_full = count_q == CntFull;
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_q];
	assign push      = push_valid && !push_full;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull) else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CntW'(1))
		else $error("queue count did not advance on push");

endmodule

[hw/rtl/rlp_back.sv]
// Back of the radix literal parser: tracks prefixes, sign and quoted form,
// accumulates digits and holds the result register.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [5:0]         default_radix,
	input  logic               tok_valid,
	output logic               tok_ready,
	input  rlp_pkg::token_t    tok,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_number,
	output logic signed [63:0] number_value
);

	rlp_pkg::phase_t phase_q, ph_cur, ph_nx;
	logic [5:0]  radix_q, radix_cur, radix_nx;
	logic        minus_q, minus_cur, minus_nx;
	logic [63:0] acc_q, acc_cur, acc_nx, addend;
	logic        bad_q, bad_cur, bad_nx;
	logic        dseen_q, dseen_cur, dseen_nx;
	logic        qf_q, qf_cur, qf_nx;
	logic [7:0]  qchar_q, qchar_nx;
	logic        p0;
	logic        pop;
	logic        res_num;
	logic [63:0] res_val;
	logic        out_valid_q;
	logic        is_number_q;
	logic [63:0] number_value_q;

	assign tok_ready    = !tok.word_end || !out_valid_q || !out_stall;
	assign pop          = tok_valid && tok_ready;
	assign out_valid    = out_valid_q;
	assign is_number    = is_number_q;
	assign number_value = number_value_q;

	always_comb begin
		p0        = tok.pos == 2'd0;
		radix_cur = p0 ? default_radix : radix_q;
		ph_cur    = p0 ? rlp_pkg::PH_START : phase_q;
		minus_cur = p0 ? 1'b0 : minus_q;
		acc_cur   = p0 ? '0 : acc_q;
		bad_cur   = p0 ? 1'b0 : bad_q;
		dseen_cur = p0 ? 1'b0 : dseen_q;
		qf_cur    = p0 ? 1'b0 : qf_q;

		case (tok.pos)
			2'd0: qf_nx = tok.is_quote;
			2'd1: qf_nx = qf_cur;
			2'd2: qf_nx = qf_cur && tok.is_quote;
			default: qf_nx = 1'b0;
		endcase
		qchar_nx = (tok.pos == 2'd1) ? tok.char_code : qchar_q;

		radix_nx = radix_cur;
		ph_nx    = ph_cur;
		minus_nx = minus_cur;
		acc_nx   = acc_cur;
		bad_nx   = bad_cur;
		dseen_nx = dseen_cur;
		// the accumulator carries the sign already: minus precedes every digit
		addend   = minus_cur ? -64'(tok.dig_val) : 64'(tok.dig_val);
		if (ph_cur == rlp_pkg::PH_START && tok.is_pct) begin
			radix_nx = rlp_pkg::RADIX_BIN;
			ph_nx    = rlp_pkg::PH_BIN;
		end else if (ph_cur inside {rlp_pkg::PH_START, rlp_pkg::PH_BIN} && tok.is_hash) begin
			radix_nx = rlp_pkg::RADIX_DEC;
			ph_nx    = rlp_pkg::PH_DEC;
		end else if (ph_cur inside {rlp_pkg::PH_START, rlp_pkg::PH_BIN, rlp_pkg::PH_DEC}
				&& tok.is_dollar) begin
			radix_nx = rlp_pkg::RADIX_HEX;
			ph_nx    = rlp_pkg::PH_HEX;
		end else if (ph_cur != rlp_pkg::PH_DIGITS && radix_cur == rlp_pkg::RADIX_DEC
				&& tok.is_minus) begin
			minus_nx = 1'b1;
			ph_nx    = rlp_pkg::PH_DIGITS;
		end else begin
			ph_nx    = rlp_pkg::PH_DIGITS;
			dseen_nx = 1'b1;
			if (!tok.dig_ok || tok.dig_val >= radix_cur) begin
				bad_nx = 1'b1;
			end else begin
				acc_nx = acc_cur * 64'(radix_cur) + addend;
			end
		end

		if (tok.pos == 2'd2 && qf_nx) begin
			res_num = 1'b1;
			res_val = 64'(qchar_q);
		end else if (dseen_nx && !bad_nx) begin
			res_num = 1'b1;
			res_val = acc_nx;
		end else begin
			res_num = 1'b0;
			res_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rlp_pkg::PH_START;
			radix_q <= rlp_pkg::RADIX_RESET;
			minus_q <= 1'b0;
			acc_q   <= '0;
			bad_q   <= 1'b0;
			dseen_q <= 1'b0;
			qf_q    <= 1'b0;
			qchar_q <= '0;
		end else if (pop) begin
			phase_q <= ph_nx;
			radix_q <= radix_nx;
			minus_q <= minus_nx;
			acc_q   <= acc_nx;
			bad_q   <= bad_nx;
			dseen_q <= dseen_nx;
			qf_q    <= qf_nx;
			qchar_q <= qchar_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && tok.word_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.word_end) begin
			is_number_q    <= res_num;
			number_value_q <= res_val;
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !is_number_q) |-> number_value_q == '0)
		else $error("invalid word with nonzero value");
	a_word_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && tok.word_end) |=> out_valid_q)
		else $error("word end gave no result");
	a_bin_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !tok.word_end && tok.pos == 2'd0 && tok.is_pct) |=> radix_q == rlp_pkg::RADIX_BIN)
		else $error("binary prefix did not set radix");

endmodule

[hw/rtl/radix_literal_parser.sv]
// Top level of the radix literal parser: radix register, front, token queue
// and back. Depends on rlp_pkg, rlp_front, rlp_queue and rlp_back.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   char_code, word_end
//   out      source     out_valid / out_stall is_number, number_value
//   cfg      sink       cfg_valid / cfg_ready default_radix
//
// One character per cycle while in_stall is low; after its last character is
// accepted, a result passes the queue entry and then the result register.
// The back: one token per cycle, 64 x 6 multiply-add, unless a result is held.
// Reset clears the word state and loads default_radix with 10.
// A stalled output holds the result; the queue then fills and raises in_stall.
`timescale 1ns / 1ps

module radix_literal_parser #(
	parameter int unsigned QueueDepth = rlp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               word_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_number,
	output logic signed [63:0] number_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [5:0]         default_radix
);

	logic [5:0]      default_radix_q;
	logic            push_valid;
	logic            push_full;
	rlp_pkg::token_t push_data;
	logic            tok_valid;
	logic            tok_ready;
	rlp_pkg::token_t tok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_radix_q <= rlp_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			default_radix_q <= default_radix;
		end
	end

	rlp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.word_end   (word_end),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_data  (push_data)
	);

	rlp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_data  (push_data),
		.pop_valid  (tok_valid),
		.pop_ready  (tok_ready),
		.pop_data   (tok)
	);

	rlp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.default_radix (default_radix_q),
		.tok_valid     (tok_valid),
		.tok_ready     (tok_ready),
		.tok           (tok),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_number     (is_number),
		.number_value  (number_value)
	);

endmodule
